FILE: sv/abba_pkg.sv
// ----------------------------------------------------------------------------
// abba_pkg: shared types and constants of the address block allocator
// Table geometry, entry layouts, table write commands, op and status codes.
// ----------------------------------------------------------------------------
package abba_pkg;

  localparam int ADDR_BITS    = 32;
  localparam int SIZE_W       = 24;
  localparam int USED_ENTRIES = 64;
  localparam int FREE_ENTRIES = 64;
  localparam int UIDX_W       = $clog2(USED_ENTRIES);
  localparam int FIDX_W       = $clog2(FREE_ENTRIES);
  localparam int MAX_ENTRIES  = (USED_ENTRIES > FREE_ENTRIES) ? USED_ENTRIES : FREE_ENTRIES;
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);

  // Largest block size, one bit wider so that sums can be checked against it
  localparam logic [SIZE_W:0] SIZE_LIMIT = {1'b0, {SIZE_W{1'b1}}};
  // One past the last address, two bits wider than an address
  localparam logic [ADDR_BITS+1:0] ADDR_END = (ADDR_BITS+2)'(1) << ADDR_BITS;

  // Command codes
  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_FREE   = 3'd1;
  localparam logic [2:0] OP_SHRINK = 3'd2;
  localparam logic [2:0] OP_EXTEND = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_BLOCK = 3'd2;
  localparam logic [2:0] ST_ZERO      = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_SPACE     = 3'd5;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    size;
    logic                 backed;
  } used_ent_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    size;
  } free_ent_t;

  // Table write command: data_en writes the entry, the valid bit is always written
  typedef struct packed {
    logic              en;
    logic              data_en;
    logic              vld;
    logic [UIDX_W-1:0] idx;
    used_ent_t         ent;
  } used_wr_t;

  typedef struct packed {
    logic              en;
    logic              data_en;
    logic              vld;
    logic [FIDX_W-1:0] idx;
    free_ent_t         ent;
  } free_wr_t;

endpackage

FILE: sv/abba_used_tab.sv
// ----------------------------------------------------------------------------
// abba_used_tab: used block table
// Entry memory with registered read and one write port, valid bits in flops.
// ----------------------------------------------------------------------------
module abba_used_tab (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [abba_pkg::UIDX_W-1:0] rd_idx,
  output abba_pkg::used_ent_t         rd_ent,
  output logic                        rd_vld,
  input  abba_pkg::used_wr_t          wr
);

  abba_pkg::used_ent_t                  mem [abba_pkg::USED_ENTRIES];
  logic [abba_pkg::USED_ENTRIES-1:0]    vld;

  // Write entry data, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr.en && wr.data_en) begin
      mem[wr.idx] <= wr.ent;
    end
    rd_ent <= mem[rd_idx];
    rd_vld <= vld[rd_idx];
  end

  // Valid bits clear at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= wr.vld;
    end
  end

endmodule

FILE: sv/abba_free_tab.sv
// ----------------------------------------------------------------------------
// abba_free_tab: free range table
// Entry memory with registered read and one write port, valid bits in flops.
// ----------------------------------------------------------------------------
module abba_free_tab (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [abba_pkg::FIDX_W-1:0] rd_idx,
  output abba_pkg::free_ent_t         rd_ent,
  output logic                        rd_vld,
  input  abba_pkg::free_wr_t          wr
);

  abba_pkg::free_ent_t                  mem [abba_pkg::FREE_ENTRIES];
  logic [abba_pkg::FREE_ENTRIES-1:0]    vld;

  // Write entry data, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr.en && wr.data_en) begin
      mem[wr.idx] <= wr.ent;
    end
    rd_ent <= mem[rd_idx];
    rd_vld <= vld[rd_idx];
  end

  // Valid bits clear at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= wr.vld;
    end
  end

endmodule

FILE: sv/address_space_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// address_space_block_allocator_unit: first-fit address block allocator
// Keeps a used block table, a free range table and a bump pointer, and runs
// allocate, free, shrink, extend and lookup commands against them.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on s_axis (op in tuser, address/size/backed in tdata), one
//   at a time; s_axis_tready is high only while the sequencer is idle.
//   Each command gives exactly one result on m_axis (status in tuser).
//   The cfg channel loads first_address, which also sets the bump pointer;
//   it is taken only while idle.
// Sweeps: commands other than zero size and unknown ops sweep a table one entry
//   per cycle through a single compare unit. Lookup takes one sweep; free, shrink
//   and allocate take one or two, extend one, three or four. Zero size and
//   unknown ops finish without a sweep.
// Reset: all table valid bits clear at once, bump pointer returns to 1; no
//   clearing pass is needed.
// Stall: a result waits in the output register until m_axis_tready; the next
//   command may be accepted meanwhile, and its result waits for the slot.
// ----------------------------------------------------------------------------
module address_space_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // address[31:0], size[55:32], backed[56], zero
  input  logic [2:0]  s_axis_tuser,   // op[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // result_address[31:0], offset[55:32], block_size[79:56]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // first_address
);

  localparam int AW = abba_pkg::ADDR_BITS;
  localparam int SW = abba_pkg::SIZE_W;
  localparam int UW = abba_pkg::UIDX_W;
  localparam int FW = abba_pkg::FIDX_W;
  localparam int CW = abba_pkg::CNT_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_UCHK  = 11'b00000001000,
    S_ACOM  = 11'b00000010000,
    S_GBCOM = 11'b00000100000,
    S_ECHK2 = 11'b00001000000,
    S_ECHK3 = 11'b00010000000,
    S_ECOM1 = 11'b00100000000,
    S_ECOM2 = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state, state_after;

  // Latched command
  logic [2:0]    op_r;
  logic [AW-1:0] addr_r;
  logic [SW-1:0] size_r;
  logic          backed_r;

  // Sweep control
  logic [CW-1:0] cnt, ev_idx, scan_len;
  logic          ev_act, scan_used, lookup_en, fit_en, subst_en;
  logic [AW:0]   ukey, fkey;
  logic [SW-1:0] fneed, gsz;
  logic [AW-1:0] gstart;

  // Used sweep results
  logic                hm, he;
  logic [UW-1:0]       m_idx, e_idx;
  abba_pkg::used_ent_t m_ent;

  // Block under extend
  logic [UW-1:0] blk_idx;
  logic [AW-1:0] blk_start, take_start;
  logic [SW-1:0] blk_size, total_r;

  // Free sweep results
  logic          hmg, hfe, hsm, hb, b_exact;
  logic [FW-1:0] mg_idx, fe_idx, sm_idx, b_idx;
  logic [AW-1:0] mg_start, sm_start, b_start;
  logic [SW-1:0] mg_size, sm_size, b_size;

  logic [AW:0]   next_addr;

  // Result
  logic [2:0]    st_r;
  logic [AW-1:0] ra_r;
  logic [SW-1:0] off_r, bs_r;
  logic          out_valid;
  logic [2:0]    out_status;
  logic [AW-1:0] out_addr;
  logic [SW-1:0] out_off, out_bs;

  // Tables
  abba_pkg::used_ent_t u_rd;
  abba_pkg::free_ent_t f_rd;
  logic                u_vld, f_vld;
  abba_pkg::used_wr_t  u_wr;
  abba_pkg::free_wr_t  f_wr;

  abba_used_tab u_used (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (cnt[UW-1:0]),
    .rd_ent (u_rd),
    .rd_vld (u_vld),
    .wr     (u_wr)
  );

  abba_free_tab u_free (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (cnt[FW-1:0]),
    .rd_ent (f_rd),
    .rd_vld (f_vld),
    .wr     (f_wr)
  );

  // Handshakes
  wire in_acc  = s_axis_tvalid && s_axis_tready;
  wire cfg_acc = cfg_valid && cfg_ready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign scan_len      = scan_used ? CW'(abba_pkg::USED_ENTRIES) : CW'(abba_pkg::FREE_ENTRIES);

  // Used entry evaluation
  logic [AW:0] u_end;
  logic        u_match, u_look;
  always_comb begin
    u_end   = {1'b0, u_rd.start} + (AW+1)'(u_rd.size);
    u_match = u_vld && ({1'b0, u_rd.start} == ukey);
    u_look  = u_vld && (u_rd.start <= addr_r) && ({1'b0, addr_r} < u_end) &&
              (!hm || (u_rd.start < m_ent.start));
  end

  // Free entry evaluation, with the pending first-fit cut applied to its entry
  logic          f_sub, f_v, f_merge, f_sm, f_fit;
  logic [SW-1:0] f_size;
  logic [AW-1:0] f_start;
  logic [AW:0]   f_end;
  logic [SW:0]   f_msum;
  always_comb begin
    f_sub   = subst_en && (ev_idx[FW-1:0] == b_idx);
    f_v     = f_vld && !(f_sub && b_exact);
    f_size  = f_sub ? (f_rd.size - fneed) : f_rd.size;
    f_start = f_sub ? (f_rd.start + AW'(fneed)) : f_rd.start;
    f_end   = {1'b0, f_rd.start} + (AW+1)'(f_rd.size);
    f_msum  = {1'b0, f_size} + {1'b0, gsz};
    f_merge = f_v && (f_end == fkey) && (f_msum <= abba_pkg::SIZE_LIMIT);
    f_sm    = f_vld && ({1'b0, f_rd.start} == fkey);
    f_fit   = fit_en && f_vld && (f_rd.size >= fneed) && (!hb || (f_rd.start < b_start));
  end

  // Shared decisions
  logic [SW-1:0]   bump_need, shr_size;
  logic [AW+1:0]   bump_sum;
  logic            bump_ovf, gb_ok, inplace;
  logic [SW:0]     ext_sum;
  logic [AW:0]     shr_gs, blk_end;
  always_comb begin
    bump_need = (state == S_ACOM) ? size_r : total_r;
    bump_sum  = {1'b0, next_addr} + (AW+2)'(bump_need);
    bump_ovf  = bump_sum > abba_pkg::ADDR_END;
    gb_ok     = hmg || hfe;
    inplace   = !hm && hsm && (sm_size >= size_r);
    ext_sum   = {1'b0, m_ent.size} + {1'b0, size_r};
    shr_size  = m_ent.size - size_r;
    shr_gs    = {1'b0, m_ent.start} + (AW+1)'(shr_size);
    blk_end   = {1'b0, m_ent.start} + (AW+1)'(m_ent.size);
  end

  // Table writes
  always_comb begin
    u_wr = '0;
    f_wr = '0;
    unique case (state)
      S_ACOM: begin
        if (hb || !bump_ovf) begin
          u_wr = '{en: 1'b1, data_en: 1'b1, vld: 1'b1, idx: e_idx,
                   ent: '{start: hb ? b_start : next_addr[AW-1:0], size: size_r,
                          backed: backed_r}};
        end
        if (hb) begin
          f_wr = '{en: 1'b1, data_en: 1'b1, vld: (b_size != size_r), idx: b_idx,
                   ent: '{start: b_start + AW'(size_r), size: b_size - size_r}};
        end
      end
      S_GBCOM, S_ECOM2: begin
        if (hmg) begin
          f_wr = '{en: 1'b1, data_en: 1'b1, vld: 1'b1, idx: mg_idx,
                   ent: '{start: mg_start, size: mg_size}};
        end else if (hfe) begin
          f_wr = '{en: 1'b1, data_en: 1'b1, vld: 1'b1, idx: fe_idx,
                   ent: '{start: gstart, size: gsz}};
        end
        if (state == S_ECOM2) begin
          u_wr = '{en: 1'b1, data_en: 1'b0, vld: 1'b0, idx: blk_idx, ent: '0};
        end else if (gb_ok) begin
          if (op_r == abba_pkg::OP_FREE) begin
            u_wr = '{en: 1'b1, data_en: 1'b0, vld: 1'b0, idx: m_idx, ent: '0};
          end else begin
            u_wr = '{en: 1'b1, data_en: 1'b1, vld: 1'b1, idx: m_idx,
                     ent: '{start: m_ent.start, size: shr_size, backed: 1'b1}};
          end
        end
      end
      S_ECHK3: begin
        if (inplace) begin
          u_wr = '{en: 1'b1, data_en: 1'b1, vld: 1'b1, idx: blk_idx,
                   ent: '{start: blk_start, size: total_r, backed: 1'b1}};
          f_wr = '{en: 1'b1, data_en: 1'b1, vld: (sm_size != size_r), idx: sm_idx,
                   ent: '{start: sm_start + AW'(size_r), size: sm_size - size_r}};
        end
      end
      S_ECOM1: begin
        if (gb_ok) begin
          u_wr = '{en: 1'b1, data_en: 1'b1, vld: 1'b1, idx: e_idx,
                   ent: '{start: take_start, size: total_r, backed: 1'b1}};
          if (hb) begin
            f_wr = '{en: 1'b1, data_en: 1'b1, vld: !b_exact, idx: b_idx,
                     ent: '{start: b_start + AW'(total_r), size: b_size - total_r}};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      next_addr <= (AW+1)'(1);
      ev_act    <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            next_addr <= {1'b0, cfg_data};
          end
          if (in_acc) begin
            op_r     <= s_axis_tuser;
            addr_r   <= s_axis_tdata[31:0];
            size_r   <= s_axis_tdata[55:32];
            backed_r <= s_axis_tdata[56];
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          // Start the used sweep keyed on the command address
          ukey        <= {1'b0, addr_r};
          lookup_en   <= (op_r == abba_pkg::OP_LOOKUP);
          scan_used   <= 1'b1;
          hm          <= 1'b0;
          he          <= 1'b0;
          cnt         <= '0;
          state_after <= S_UCHK;
          st_r        <= abba_pkg::ST_OK;
          state       <= S_SCAN;
          if (op_r > abba_pkg::OP_LOOKUP) begin
            st_r  <= abba_pkg::ST_NOT_FOUND;
            state <= S_FIN;
          end else if (size_r == '0 && op_r != abba_pkg::OP_FREE &&
                       op_r != abba_pkg::OP_LOOKUP) begin
            st_r  <= abba_pkg::ST_ZERO;
            state <= S_FIN;
          end
        end
        S_SCAN: begin
          // Advance the sweep one entry per cycle
          if (cnt < scan_len) begin
            cnt    <= cnt + CW'(1);
            ev_idx <= cnt;
            ev_act <= 1'b1;
          end else begin
            ev_act <= 1'b0;
          end
          if (ev_act && scan_used) begin
            if (!u_vld && !he) begin
              he    <= 1'b1;
              e_idx <= ev_idx[UW-1:0];
            end
            if (lookup_en ? u_look : (u_match && !hm)) begin
              hm    <= 1'b1;
              m_idx <= ev_idx[UW-1:0];
              m_ent <= u_rd;
            end
          end
          if (ev_act && !scan_used) begin
            if (f_merge && !hmg) begin
              hmg      <= 1'b1;
              mg_idx   <= ev_idx[FW-1:0];
              mg_start <= f_start;
              mg_size  <= f_msum[SW-1:0];
            end
            if (!f_v && !hfe) begin
              hfe    <= 1'b1;
              fe_idx <= ev_idx[FW-1:0];
            end
            if (f_sm && !hsm) begin
              hsm      <= 1'b1;
              sm_idx   <= ev_idx[FW-1:0];
              sm_start <= f_rd.start;
              sm_size  <= f_rd.size;
            end
            if (f_fit) begin
              hb      <= 1'b1;
              b_idx   <= ev_idx[FW-1:0];
              b_start <= f_rd.start;
              b_size  <= f_rd.size;
              b_exact <= (f_rd.size == fneed);
            end
          end
          if (cnt == scan_len && !ev_act) begin
            state <= state_after;
          end
        end
        S_UCHK: begin
          // Act on the used sweep: report, or prepare the next sweep for the command
          scan_used <= 1'b0;
          cnt       <= '0;
          hmg       <= 1'b0;
          hfe       <= 1'b0;
          hsm       <= 1'b0;
          hb        <= 1'b0;
          fit_en    <= 1'b0;
          subst_en  <= 1'b0;
          state     <= S_FIN;
          case (op_r)
            abba_pkg::OP_ALLOC: begin
              if (!he) begin
                st_r <= abba_pkg::ST_FULL;
              end else begin
                fit_en      <= 1'b1;
                fneed       <= size_r;
                state_after <= S_ACOM;
                state       <= S_SCAN;
              end
            end
            abba_pkg::OP_FREE: begin
              if (!hm) begin
                st_r <= abba_pkg::ST_NOT_FOUND;
              end else begin
                fkey        <= {1'b0, m_ent.start};
                gstart      <= m_ent.start;
                gsz         <= m_ent.size;
                state_after <= S_GBCOM;
                state       <= S_SCAN;
              end
            end
            abba_pkg::OP_SHRINK: begin
              if (!hm) begin
                st_r <= abba_pkg::ST_NOT_FOUND;
              end else if (!m_ent.backed || m_ent.size <= size_r) begin
                st_r <= abba_pkg::ST_BAD_BLOCK;
              end else begin
                fkey        <= shr_gs;
                gstart      <= shr_gs[AW-1:0];
                gsz         <= size_r;
                state_after <= S_GBCOM;
                state       <= S_SCAN;
              end
            end
            abba_pkg::OP_EXTEND: begin
              if (!hm) begin
                st_r <= abba_pkg::ST_NOT_FOUND;
              end else if (!m_ent.backed) begin
                st_r <= abba_pkg::ST_BAD_BLOCK;
              end else if (ext_sum > abba_pkg::SIZE_LIMIT) begin
                st_r <= abba_pkg::ST_SPACE;
              end else begin
                // Second used sweep: is a block starting at this block's end
                blk_idx     <= m_idx;
                blk_start   <= m_ent.start;
                blk_size    <= m_ent.size;
                total_r     <= ext_sum[SW-1:0];
                ukey        <= blk_end;
                lookup_en   <= 1'b0;
                scan_used   <= 1'b1;
                hm          <= 1'b0;
                he          <= 1'b0;
                state_after <= S_ECHK2;
                state       <= S_SCAN;
              end
            end
            default: begin
              if (hm) begin
                ra_r  <= m_ent.start;
                off_r <= SW'(addr_r - m_ent.start);
                bs_r  <= m_ent.size;
              end else begin
                st_r <= abba_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
        S_ACOM: begin
          // Cut from the first fit, else bump
          state <= S_FIN;
          bs_r  <= size_r;
          if (hb) begin
            ra_r <= b_start;
          end else if (bump_ovf) begin
            st_r <= abba_pkg::ST_SPACE;
          end else begin
            ra_r      <= next_addr[AW-1:0];
            next_addr <= bump_sum[AW:0];
          end
        end
        S_GBCOM: begin
          state <= S_FIN;
          ra_r  <= addr_r;
          bs_r  <= (op_r == abba_pkg::OP_FREE) ? m_ent.size : shr_size;
          if (!gb_ok) begin
            st_r <= abba_pkg::ST_FULL;
          end
        end
        S_ECHK2: begin
          // Free sweep: range at the block end, and first fit for the grown size
          scan_used   <= 1'b0;
          cnt         <= '0;
          hmg         <= 1'b0;
          hfe         <= 1'b0;
          hsm         <= 1'b0;
          hb          <= 1'b0;
          fit_en      <= 1'b1;
          subst_en    <= 1'b0;
          fkey        <= ukey;
          fneed       <= total_r;
          gsz         <= '0;
          state_after <= S_ECHK3;
          state       <= S_SCAN;
        end
        S_ECHK3: begin
          state <= S_FIN;
          ra_r  <= blk_start;
          bs_r  <= total_r;
          if (!inplace) begin
            if (!he) begin
              st_r <= abba_pkg::ST_FULL;
            end else if (!hb && bump_ovf) begin
              st_r <= abba_pkg::ST_SPACE;
            end else begin
              // Relocate: sweep free table to give back the old range
              take_start  <= hb ? b_start : next_addr[AW-1:0];
              scan_used   <= 1'b0;
              cnt         <= '0;
              hmg         <= 1'b0;
              hfe         <= 1'b0;
              fit_en      <= 1'b0;
              subst_en    <= hb;
              fkey        <= {1'b0, blk_start};
              gstart      <= blk_start;
              gsz         <= blk_size;
              state_after <= S_ECOM1;
              state       <= S_SCAN;
            end
          end
        end
        S_ECOM1: begin
          if (!gb_ok) begin
            st_r  <= abba_pkg::ST_FULL;
            state <= S_FIN;
          end else begin
            if (!hb) begin
              next_addr <= bump_sum[AW:0];
            end
            state <= S_ECOM2;
          end
        end
        S_ECOM2: begin
          ra_r  <= take_start;
          bs_r  <= total_r;
          state <= S_FIN;
        end
        S_FIN: begin
          // Hand the result to the output register once it is free
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_status <= st_r;
            out_addr   <= (st_r == abba_pkg::ST_OK) ? ra_r : '0;
            out_off    <= (st_r == abba_pkg::ST_OK && op_r == abba_pkg::OP_LOOKUP) ?
                          off_r : '0;
            out_bs     <= (st_r == abba_pkg::ST_OK) ? bs_r : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {out_bs, out_off, out_addr};

  // One command at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("item accepted while a command is in progress");

  // Failed commands report no address or size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != abba_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("failed command returned nonzero data");

  // A configuration write loads the bump pointer
  a_cfg_load: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> (next_addr == {1'b0, $past(cfg_data)}))
    else $error("bump pointer not loaded by configuration write");

endmodule

FILE: bench/address_space_block_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// address_space_block_allocator_unit_test: self-checking bench for the allocator
// Queues commands for a clocked driver and predicts every result with its own
// copy of the used table, free table and bump pointer. A clocked monitor
// compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module address_space_block_allocator_unit_test;

  localparam int WATCH_LIMIT = 6000;
  localparam int DRAIN_WAIT  = 320;
  localparam int LONG_HOLD   = 700;

  typedef struct {
    logic [2:0]                  op;
    logic [31:0]                 addr;
    logic [abba_pkg::SIZE_W-1:0] size;
    logic                        backed;
  } cmd_t;

  typedef struct {
    logic [2:0]                  status;
    logic [31:0]                 addr;
    logic [abba_pkg::SIZE_W-1:0] offset;
    logic [abba_pkg::SIZE_W-1:0] bsize;
  } outcome_t;

  typedef struct {
    bit              v;
    longint unsigned st;
    int unsigned     sz;
    bit              bk;
  } ublk_t;

  typedef struct {
    bit              v;
    longint unsigned st;
    int unsigned     sz;
  } frng_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  address_space_block_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Allocator mirror
  ublk_t           used_tab [abba_pkg::USED_ENTRIES];
  frng_t           free_tab [abba_pkg::FREE_ENTRIES];
  longint unsigned bump_ptr;

  cmd_t     pending_cmds[$];
  outcome_t expected_outcomes[$];
  cmd_t     cur_cmd;
  bit       took = 0;
  bit       quiet = 0;
  bit       hold_trigger = 0;
  int       errors = 0;
  int       n_cmds = 0;
  int       n_ok = 0;
  int       n_fail = 0;
  int       idle_cycles = 0;

  function automatic int find_block(longint unsigned a);
    for (int i = 0; i < abba_pkg::USED_ENTRIES; i++)
      if (used_tab[i].v && used_tab[i].st == a) return i;
    return -1;
  endfunction

  function automatic logic [2:0] release_range(longint unsigned s, int unsigned sz);
    for (int j = 0; j < abba_pkg::FREE_ENTRIES; j++)
      if (free_tab[j].v && free_tab[j].st + free_tab[j].sz == s &&
          longint'(free_tab[j].sz) + sz <= longint'(abba_pkg::SIZE_LIMIT)) begin
        free_tab[j].sz += sz;
        return abba_pkg::ST_OK;
      end
    for (int j = 0; j < abba_pkg::FREE_ENTRIES; j++)
      if (!free_tab[j].v) begin
        free_tab[j].v = 1;
        free_tab[j].st = s;
        free_tab[j].sz = sz;
        return abba_pkg::ST_OK;
      end
    return abba_pkg::ST_FULL;
  endfunction

  function automatic logic [2:0] place_block(int unsigned sz, bit bk,
                                             output longint unsigned s);
    int slot;
    int pick;
    slot = -1;
    pick = -1;
    s = 0;
    for (int i = 0; i < abba_pkg::USED_ENTRIES; i++)
      if (slot < 0 && !used_tab[i].v) slot = i;
    if (slot < 0) return abba_pkg::ST_FULL;
    for (int j = 0; j < abba_pkg::FREE_ENTRIES; j++)
      if (free_tab[j].v && free_tab[j].sz >= sz &&
          (pick < 0 || free_tab[j].st < free_tab[pick].st)) pick = j;
    if (pick >= 0) begin
      s = free_tab[pick].st;
      if (free_tab[pick].sz == sz) begin
        free_tab[pick].v = 0;
      end else begin
        free_tab[pick].st += sz;
        free_tab[pick].sz -= sz;
      end
    end else begin
      if (bump_ptr + sz > (64'd1 << abba_pkg::ADDR_BITS)) return abba_pkg::ST_SPACE;
      s = bump_ptr;
      bump_ptr += sz;
    end
    used_tab[slot] = '{1, s, sz, bk};
    return abba_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] grow_block(longint unsigned a, int unsigned add,
                                            output longint unsigned ra,
                                            output int unsigned bs);
    int              i;
    int unsigned     total;
    longint unsigned tail;
    longint unsigned ns;
    logic [2:0]      st;
    ublk_t           saved_used [abba_pkg::USED_ENTRIES];
    frng_t           saved_free [abba_pkg::FREE_ENTRIES];
    longint unsigned saved_bump;
    ra = 0;
    bs = 0;
    i = find_block(a);
    if (i < 0) return abba_pkg::ST_NOT_FOUND;
    if (!used_tab[i].bk) return abba_pkg::ST_BAD_BLOCK;
    if (longint'(used_tab[i].sz) + add > longint'(abba_pkg::SIZE_LIMIT))
      return abba_pkg::ST_SPACE;
    total = used_tab[i].sz + add;
    tail = used_tab[i].st + used_tab[i].sz;
    // Grow in place when a free range begins right at the block end
    if (find_block(tail) < 0) begin
      for (int j = 0; j < abba_pkg::FREE_ENTRIES; j++)
        if (free_tab[j].v && free_tab[j].st == tail) begin
          if (free_tab[j].sz >= add) begin
            if (free_tab[j].sz == add) begin
              free_tab[j].v = 0;
            end else begin
              free_tab[j].st += add;
              free_tab[j].sz -= add;
            end
            used_tab[i].sz = total;
            ra = used_tab[i].st;
            bs = total;
            return abba_pkg::ST_OK;
          end
          break;
        end
    end
    // Relocate, rolling back on any failure
    saved_used = used_tab;
    saved_free = free_tab;
    saved_bump = bump_ptr;
    st = place_block(total, 1, ns);
    if (st == abba_pkg::ST_OK) st = release_range(used_tab[i].st, used_tab[i].sz);
    if (st != abba_pkg::ST_OK) begin
      used_tab = saved_used;
      free_tab = saved_free;
      bump_ptr = saved_bump;
      return st;
    end
    used_tab[i].v = 0;
    ra = ns;
    bs = total;
    return abba_pkg::ST_OK;
  endfunction

  function automatic outcome_t predict_outcome(cmd_t c);
    outcome_t        o;
    logic [2:0]      st;
    longint unsigned ra;
    longint unsigned off;
    int unsigned     bs;
    int              i;
    int              hit;
    st = abba_pkg::ST_NOT_FOUND;
    ra = 0;
    off = 0;
    bs = 0;
    case (c.op)
      abba_pkg::OP_ALLOC: begin
        if (c.size == 0) begin
          st = abba_pkg::ST_ZERO;
        end else begin
          st = place_block(c.size, c.backed, ra);
          bs = c.size;
        end
      end
      abba_pkg::OP_FREE: begin
        i = find_block(c.addr);
        if (i >= 0) begin
          st = release_range(used_tab[i].st, used_tab[i].sz);
          if (st == abba_pkg::ST_OK) begin
            used_tab[i].v = 0;
            ra = c.addr;
            bs = used_tab[i].sz;
          end
        end
      end
      abba_pkg::OP_SHRINK: begin
        i = find_block(c.addr);
        if (c.size == 0) begin
          st = abba_pkg::ST_ZERO;
        end else if (i >= 0) begin
          if (!used_tab[i].bk || used_tab[i].sz <= c.size) begin
            st = abba_pkg::ST_BAD_BLOCK;
          end else begin
            bs = used_tab[i].sz - c.size;
            st = release_range(used_tab[i].st + bs, c.size);
            if (st == abba_pkg::ST_OK) begin
              used_tab[i].sz = bs;
              ra = c.addr;
            end
          end
        end
      end
      abba_pkg::OP_EXTEND: begin
        if (c.size == 0) st = abba_pkg::ST_ZERO;
        else st = grow_block(c.addr, c.size, ra, bs);
      end
      abba_pkg::OP_LOOKUP: begin
        hit = -1;
        for (int k = 0; k < abba_pkg::USED_ENTRIES; k++)
          if (used_tab[k].v && used_tab[k].st <= c.addr &&
              c.addr < used_tab[k].st + used_tab[k].sz &&
              (hit < 0 || used_tab[k].st < used_tab[hit].st)) hit = k;
        if (hit >= 0) begin
          st = abba_pkg::ST_OK;
          ra = used_tab[hit].st;
          off = c.addr - ra;
          bs = used_tab[hit].sz;
        end
      end
      default: st = abba_pkg::ST_NOT_FOUND;
    endcase
    if (st != abba_pkg::ST_OK) begin
      ra = 0;
      off = 0;
      bs = 0;
    end
    o.status = st;
    o.addr = ra[31:0];
    o.offset = off[abba_pkg::SIZE_W-1:0];
    o.bsize = bs[abba_pkg::SIZE_W-1:0];
    return o;
  endfunction

  // Accept commands and record their predicted results
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_outcomes.push_back(predict_outcome(cur_cmd));
      took = 1;
      n_cmds++;
    end
  end

  // Drive commands at the falling edge, with random gaps
  int send_gap = 0;
  always @(negedge clk) begin
    if (!s_axis_tvalid || took) begin
      took = 0;
      if (rst || send_gap > 0 || pending_cmds.size() == 0) begin
        if (send_gap > 0) send_gap--;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, cur_cmd.backed, cur_cmd.size, cur_cmd.addr};
        s_axis_tuser <= cur_cmd.op;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end
    end
  end

  // Drive the result ready with random stalls and one long hold-off
  int recv_gap = 0;
  int recv_hold = 0;
  always @(negedge clk) begin
    if (hold_trigger) begin
      hold_trigger = 0;
      recv_hold = LONG_HOLD;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 15);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no prediction waiting");
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (want.status == abba_pkg::ST_OK) n_ok++;
        else n_fail++;
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] !== want.addr) begin
          $error("result_address: expected %h actual %h", want.addr, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[55:32] !== want.offset) begin
          $error("offset: expected %h actual %h", want.offset, m_axis_tdata[55:32]);
          errors++;
        end
        if (m_axis_tdata[79:56] !== want.bsize) begin
          $error("block_size: expected %h actual %h", want.bsize, m_axis_tdata[79:56]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL address_space_block_allocator_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_cmd(logic [2:0] op, logic [31:0] a, logic [abba_pkg::SIZE_W-1:0] sz,
                          logic bk);
    cmd_t c;
    c.op = op;
    c.addr = a;
    c.size = sz;
    c.backed = bk;
    pending_cmds.push_back(c);
  endtask

  // Hold until every queued command is accepted and every result is back
  task automatic drain_all();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_first_address(logic [31:0] v);
    drain_all();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bump_ptr = 64'(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [abba_pkg::SIZE_W-1:0] pick_size();
    int          r;
    logic [31:0] w;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) begin
      w = $urandom();
      return w[abba_pkg::SIZE_W-1:0];
    end
    if (r < 10) return abba_pkg::SIZE_LIMIT[abba_pkg::SIZE_W-1:0];
    w = $urandom_range(1, 64);
    return w[abba_pkg::SIZE_W-1:0];
  endfunction

  function automatic longint unsigned pick_block_start();
    int idx[$];
    for (int i = 0; i < abba_pkg::USED_ENTRIES; i++)
      if (used_tab[i].v) idx.push_back(i);
    if (idx.size() == 0) return 64'($urandom());
    return used_tab[idx[$urandom_range(0, idx.size() - 1)]].st;
  endfunction

  // Mostly well-formed commands against live blocks, the rest noise
  task automatic push_random_cmd();
    int              r;
    longint unsigned a;
    logic [63:0]     la;
    logic [31:0]     w1;
    logic [31:0]     w2;
    logic [31:0]     w3;
    r = $urandom_range(0, 99);
    a = pick_block_start();
    w1 = $urandom();
    w2 = $urandom();
    w3 = $urandom();
    if (r < 28) begin
      push_cmd(abba_pkg::OP_ALLOC, w1, pick_size(), w3[1:0] != 2'b00);
    end else if (r < 44) begin
      push_cmd(abba_pkg::OP_FREE, a[31:0], w2[abba_pkg::SIZE_W-1:0], w3[0]);
    end else if (r < 56) begin
      w2 = $urandom_range(0, 20);
      push_cmd(abba_pkg::OP_SHRINK, a[31:0], w2[abba_pkg::SIZE_W-1:0], w3[0]);
    end else if (r < 72) begin
      push_cmd(abba_pkg::OP_EXTEND, a[31:0], pick_size(), w3[0]);
    end else if (r < 88) begin
      la = a + 64'($urandom_range(0, 80));
      push_cmd(abba_pkg::OP_LOOKUP, la[31:0], w2[abba_pkg::SIZE_W-1:0], w3[0]);
    end else begin
      push_cmd(w1[2:0], w2, w3[abba_pkg::SIZE_W-1:0], w1[3]);
    end
  endtask

  initial begin
    logic [31:0] first_vals [6];
    for (int i = 0; i < abba_pkg::USED_ENTRIES; i++) used_tab[i] = '{0, 0, 0, 0};
    for (int j = 0; j < abba_pkg::FREE_ENTRIES; j++) free_tab[j] = '{0, 0, 0};
    bump_ptr = 1;
    first_vals = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_1000, 32'h0, 32'h1, 32'h0};
    first_vals[3] = $urandom();
    if (first_vals[3] == 0) first_vals[3] = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero size, unbacked, too small, relocation, merge limit, bad ops
    push_cmd(abba_pkg::OP_ALLOC, 0, 1, 1);                         // at 1
    push_cmd(abba_pkg::OP_ALLOC, 0, 0, 1);
    push_cmd(abba_pkg::OP_ALLOC, 0, abba_pkg::SIZE_LIMIT[abba_pkg::SIZE_W-1:0], 0); // at 2
    push_cmd(abba_pkg::OP_ALLOC, 0, 16, 1);                        // at 0x1000001
    push_cmd(abba_pkg::OP_LOOKUP, 1, 0, 0);
    push_cmd(abba_pkg::OP_LOOKUP, 0, 0, 0);
    push_cmd(abba_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 0, 0);
    push_cmd(abba_pkg::OP_LOOKUP, 32'h0100_0000, 0, 0);
    push_cmd(abba_pkg::OP_SHRINK, 1, 0, 0);
    push_cmd(abba_pkg::OP_SHRINK, 2, 1, 0);
    push_cmd(abba_pkg::OP_EXTEND, 2, 1, 0);
    push_cmd(abba_pkg::OP_SHRINK, 1, 1, 0);
    push_cmd(abba_pkg::OP_EXTEND, 1, abba_pkg::SIZE_LIMIT[abba_pkg::SIZE_W-1:0], 0);
    push_cmd(abba_pkg::OP_EXTEND, 1, 0, 0);
    push_cmd(abba_pkg::OP_EXTEND, 1, 3, 0);
    push_cmd(abba_pkg::OP_FREE, 2, 0, 0);
    push_cmd(abba_pkg::OP_FREE, 32'h0100_0001, 0, 0);
    push_cmd(abba_pkg::OP_FREE, 32'h0100_0001, 0, 0);
    push_cmd(3'd5, 32'hFFFF_FFFF, abba_pkg::SIZE_LIMIT[abba_pkg::SIZE_W-1:0], 1);
    push_cmd(3'd6, 0, 0, 0);
    push_cmd(3'd7, 1, 1, 1);
    push_cmd(abba_pkg::OP_ALLOC, 0, 8, 1);
    push_cmd(abba_pkg::OP_EXTEND, 32'h0100_0019, 4, 0);
    push_cmd(abba_pkg::OP_SHRINK, 32'h0100_0019, 2, 0);
    drain_all();

    // Random phases across first_address settings
    for (int p = 0; p < 6; p++) begin
      write_first_address(first_vals[p]);
      if (p == 5) quiet = 1;
      for (int b = 0; b < 16; b++) begin
        if (p == 1 && b == 2) hold_trigger = 1;
        for (int k = 0; k < 10; k++) push_random_cmd();
        if (p == 2 && b == 5) drain_all();
        while (pending_cmds.size() != 0) @(posedge clk);
      end
    end

    drain_all();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d commands over six first_address settings: %0d ok, %0d error results.",
             n_cmds, n_ok, n_fail);
    if (errors == 0) begin
      $display("PASS address_space_block_allocator_unit");
    end else begin
      $display("FAIL address_space_block_allocator_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/abba_pkg.sv
sv/abba_used_tab.sv
sv/abba_free_tab.sv
sv/address_space_block_allocator_unit.sv
bench/address_space_block_allocator_unit_test.sv
